[src/fprf_pkg.sv]
package fprf_pkg;

  localparam int REG_COUNT = 32;
  localparam int ROW_COUNT = REG_COUNT / 2;
  localparam int IDX_W     = $clog2(REG_COUNT);
  localparam int ROW_W     = $clog2(ROW_COUNT);
  localparam int DATA_W    = 64;
  localparam int WORD_W    = 32;

  typedef enum logic [1:0] {
    OP_READ32  = 2'd0,
    OP_READ64  = 2'd1,
    OP_WRITE32 = 2'd2,
    OP_WRITE64 = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Request into the banked store: even entries in one bank, odd in the other.
  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic [ROW_W-1:0]  wr_row;
    logic              even_we;
    logic              odd_we;
    logic [DATA_W-1:0] even_wdata;
    logic [DATA_W-1:0] odd_wdata;
  } bank_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] even_data;
    logic [DATA_W-1:0] odd_data;
  } bank_rsp_t;

  function automatic logic [DATA_W-1:0] sext32(input logic [WORD_W-1:0] w);
    sext32 = {{(DATA_W-WORD_W){w[WORD_W-1]}}, w};
  endfunction

endpackage

[src/fprf_ram.sv]
module fprf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fprf_bank_store.sv]
module fprf_bank_store (
  input  logic                clk,
  input  logic                rst,
  input  fprf_pkg::bank_req_t req,
  output fprf_pkg::bank_rsp_t rsp
);

  logic [fprf_pkg::ROW_COUNT-1:0] even_vld;
  logic [fprf_pkg::ROW_COUNT-1:0] odd_vld;
  logic                           even_vld_q;
  logic                           odd_vld_q;
  logic [fprf_pkg::DATA_W-1:0]    even_dout;
  logic [fprf_pkg::DATA_W-1:0]    odd_dout;

  fprf_ram #(.WIDTH(fprf_pkg::DATA_W), .DEPTH(fprf_pkg::ROW_COUNT)) u_even_ram (
    .clk   (clk),
    .we    (req.even_we),
    .waddr (req.wr_row),
    .wdata (req.even_wdata),
    .re    (req.rd_en),
    .raddr (req.rd_row),
    .rdata (even_dout)
  );

  fprf_ram #(.WIDTH(fprf_pkg::DATA_W), .DEPTH(fprf_pkg::ROW_COUNT)) u_odd_ram (
    .clk   (clk),
    .we    (req.odd_we),
    .waddr (req.wr_row),
    .wdata (req.odd_wdata),
    .re    (req.rd_en),
    .raddr (req.rd_row),
    .rdata (odd_dout)
  );

  // Entries never written read as zero; valid bits track the same read latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      even_vld   <= '0;
      odd_vld    <= '0;
      even_vld_q <= 1'b0;
      odd_vld_q  <= 1'b0;
    end else begin
      if (req.even_we) begin
        even_vld[req.wr_row] <= 1'b1;
      end
      if (req.odd_we) begin
        odd_vld[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        even_vld_q <= even_vld[req.rd_row];
        odd_vld_q  <= odd_vld[req.rd_row];
      end
    end
  end

  assign rsp.even_data = even_vld_q ? even_dout : '0;
  assign rsp.odd_data  = odd_vld_q  ? odd_dout  : '0;

endmodule

[src/fpu_register_file_paired_mode_core.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// in       | in_valid / in_ready  | operation, fpr_num, write_value
// out      | out_valid / out_ready| read_value
// cfg      | cfg_wr_en            | cfg_wr_data (full_width_mode)
//
// Each word has an accept step, which issues the bank read, and an execute
// step, which merges the read data, writes back and loads the output register.
// The registered read of the bank memories and a single word in flight make the steps separate.
// Reset clears the mode and the per-entry valid bits; no clearing pass.
// A full output register holds the block in its execute step until taken.
module fpu_register_file_paired_mode_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            operation,
  input  logic [fprf_pkg::IDX_W-1:0]            fpr_num,
  input  logic signed [fprf_pkg::DATA_W-1:0]    write_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fprf_pkg::DATA_W-1:0]    read_value,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data
);

  fprf_pkg::state_t            state;
  fprf_pkg::state_t            state_next;
  fprf_pkg::op_t               op_in;
  fprf_pkg::op_t               op_q;
  logic                        odd_q;
  logic [fprf_pkg::ROW_W-1:0]  row_in;
  logic [fprf_pkg::ROW_W-1:0]  row_q;
  logic [fprf_pkg::DATA_W-1:0] wval_q;
  logic                        full_width_mode;
  logic                        accept;
  logic                        commit;
  logic [fprf_pkg::DATA_W-1:0] result;
  logic [fprf_pkg::DATA_W-1:0] sel_data;
  fprf_pkg::bank_req_t         req;
  fprf_pkg::bank_rsp_t         rsp;

  assign op_in  = fprf_pkg::op_t'(operation);
  assign accept = in_valid && in_ready;
  assign commit = (state == fprf_pkg::ST_EXEC) && (!out_valid || out_ready);

  // In paired mode a 64-bit access rounds an odd index up to the next pair; row wraps.
  always_comb begin
    row_in = fpr_num[fprf_pkg::IDX_W-1:1];
    if (!full_width_mode && (op_in == fprf_pkg::OP_READ64 || op_in == fprf_pkg::OP_WRITE64)
        && fpr_num[0]) begin
      row_in = fpr_num[fprf_pkg::IDX_W-1:1] +
               {{(fprf_pkg::ROW_W-1){1'b0}}, 1'b1};
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      full_width_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      full_width_mode <= cfg_wr_data;
    end
  end

  // Latch the word at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_in;
      odd_q  <= fpr_num[0];
      row_q  <= row_in;
      wval_q <= write_value;
    end
  end

  fprf_bank_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Read both banks at accept; merge and write back in the execute step.
  always_comb begin
    sel_data       = odd_q ? rsp.odd_data : rsp.even_data;
    result         = '0;
    req.rd_en      = accept;
    req.rd_row     = row_in;
    req.wr_row     = row_q;
    req.even_we    = 1'b0;
    req.odd_we     = 1'b0;
    req.even_wdata = fprf_pkg::sext32(wval_q[fprf_pkg::WORD_W-1:0]);
    req.odd_wdata  = fprf_pkg::sext32(wval_q[fprf_pkg::WORD_W-1:0]);
    case (op_q)
      fprf_pkg::OP_READ32: begin
        result = fprf_pkg::sext32(sel_data[fprf_pkg::WORD_W-1:0]);
      end
      fprf_pkg::OP_READ64: begin
        if (full_width_mode) begin
          result = sel_data;
        end else begin
          result = {rsp.odd_data[fprf_pkg::WORD_W-1:0], rsp.even_data[fprf_pkg::WORD_W-1:0]};
        end
      end
      fprf_pkg::OP_WRITE32: begin
        req.even_we = commit && !odd_q;
        req.odd_we  = commit && odd_q;
      end
      fprf_pkg::OP_WRITE64: begin
        if (full_width_mode) begin
          req.even_wdata = wval_q;
          req.odd_wdata  = wval_q;
          req.even_we    = commit && !odd_q;
          req.odd_we     = commit && odd_q;
        end else begin
          // Low word zero-extended in the even entry, high word sign-extended in the odd
          req.even_wdata = {{(fprf_pkg::DATA_W-fprf_pkg::WORD_W){1'b0}},
                            wval_q[fprf_pkg::WORD_W-1:0]};
          req.odd_wdata  = fprf_pkg::sext32(wval_q[fprf_pkg::DATA_W-1:fprf_pkg::WORD_W]);
          req.even_we    = commit;
          req.odd_we     = commit;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fprf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      fprf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = fprf_pkg::ST_EXEC;
        end
      end
      fprf_pkg::ST_EXEC: begin
        if (commit) begin
          state_next = fprf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fprf_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      read_value <= result;
    end
  end

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == fprf_pkg::ST_EXEC)
    else $error("accepted word did not enter execute step");

  a_out_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == fprf_pkg::ST_EXEC)
    else $error("result appeared without an execute step");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    (req.even_we || req.odd_we) |-> state == fprf_pkg::ST_EXEC)
    else $error("bank write outside execute step");

  a_pair_write_mode: assert property (@(posedge clk) disable iff (rst)
    (req.even_we && req.odd_we) |-> !full_width_mode)
    else $error("both banks written in full width mode");
`endif

endmodule
